>>> hdl/mfw_pkg.sv
package mfw_pkg;

    localparam int PIX_W    = 8;
    localparam int COORD_W  = 8;
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int DIM_W    = 9;
    localparam int HALF_W   = 2;
    localparam int CNT_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;
    localparam int WIN_MAX  = 49;
    localparam int WIN_IDX_W = 6;
    localparam int QDEPTH   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF  = 2'd2;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // classified job passed from front to back
    typedef struct packed {
        logic               flag;      // out of frame
        logic               cmd;
        logic [COORD_W-1:0] r0;
        logic [COORD_W-1:0] r1;
        logic [COORD_W-1:0] c0;
        logic [COORD_W-1:0] c1;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pix;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_RANK, ST_PICK, ST_OUT
    } state_t;

endpackage

>>> hdl/mfw_ram.sv
module mfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/mfw_front.sv
module mfw_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [mfw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mfw_pkg::CFG_DAT_W-1:0]        cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 in_cmd,
    input  logic [mfw_pkg::COORD_W-1:0]          in_row,
    input  logic [mfw_pkg::COORD_W-1:0]          in_col,
    input  logic [mfw_pkg::PIX_W-1:0]            in_pix,
    output logic                                 q_valid,
    input  logic                                 q_ready,
    output mfw_pkg::job_t                        q_job
);
    import mfw_pkg::*;

    logic [DIM_W-1:0]  fw_reg, fh_reg;
    logic [HALF_W-1:0] half_reg;
    job_t              slot_reg [QDEPTH];
    logic [0:0]        wp_reg, rp_reg;
    logic [1:0]        cnt_reg;
    logic              push, pop;
    job_t              job;
    logic [COORD_W:0]  rsum, csum, fhm1, fwm1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg   <= DIM_W'(256);
            fh_reg   <= DIM_W'(256);
            half_reg <= HALF_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  fw_reg   <= cfg_data;
                REG_FRAME_HEIGHT: fh_reg   <= cfg_data;
                REG_WINDOW_HALF:  half_reg <= cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // frame regs above 256 behave as 256; coords are 8 bits so compare is enough
    always_comb begin
        fhm1 = (fh_reg > DIM_W'(256)) ? (COORD_W+1)'(255) : fh_reg - 1'b1;
        fwm1 = (fw_reg > DIM_W'(256)) ? (COORD_W+1)'(255) : fw_reg - 1'b1;
        rsum = {1'b0, in_row} + {{(COORD_W-1){1'b0}}, half_reg};
        csum = {1'b0, in_col} + {{(COORD_W-1){1'b0}}, half_reg};
        job.flag = (fh_reg == '0) || (fw_reg == '0) ||
                   ({1'b0, in_row} > fhm1) || ({1'b0, in_col} > fwm1);
        job.cmd  = in_cmd;
        job.row  = in_row;
        job.col  = in_col;
        job.pix  = in_pix;
        job.r0   = (in_row >= COORD_W'(half_reg)) ? in_row - COORD_W'(half_reg) : '0;
        job.c0   = (in_col >= COORD_W'(half_reg)) ? in_col - COORD_W'(half_reg) : '0;
        job.r1   = (rsum <= fhm1) ? rsum[COORD_W-1:0] : fhm1[COORD_W-1:0];
        job.c1   = (csum <= fwm1) ? csum[COORD_W-1:0] : fwm1[COORD_W-1:0];
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_job    = slot_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

>>> hdl/mfw_back.sv
module mfw_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  mfw_pkg::job_t               q_job,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mfw_pkg::PIX_W-1:0]   m_value,
    output logic [mfw_pkg::CNT_W-1:0]   m_count,
    output logic                        m_status
);
    import mfw_pkg::*;

    state_t state_reg, state_next;
    job_t   job_reg;
    logic [COORD_W-1:0] r_reg, c_reg;
    logic [CNT_W-1:0]   k_reg;
    logic               rd_pend_reg;
    logic [WIN_IDX_W-1:0] i_reg, j_reg;
    logic               cmp_pend_reg, jdone_reg;
    logic [CNT_W-1:0]   gt_reg, ge_reg;
    logic [PIX_W-1:0]   res_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               st_reg, ov_reg;
    logic               ram_we, win_we, last_rd, last_j, take, cand_hit;
    logic [PIX_W-1:0]   rdata, vi, vj;

    mfw_ram #(.WIDTH(PIX_W), .DEPTH(1 << ADDR_W)) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr({q_job.row, q_job.col}),
        .wdata(q_job.pix),
        .raddr({r_reg, c_reg}),
        .rdata(rdata)
    );

    // two copies of the window: one walks the pass, one holds the candidate
    mfw_ram #(.WIDTH(PIX_W), .DEPTH(WIN_MAX)) u_win_j (
        .aclk (aclk),
        .we   (win_we),
        .waddr(k_reg),
        .wdata(rdata),
        .raddr(j_reg),
        .rdata(vj)
    );

    mfw_ram #(.WIDTH(PIX_W), .DEPTH(WIN_MAX)) u_win_i (
        .aclk (aclk),
        .we   (win_we),
        .waddr(k_reg),
        .wdata(rdata),
        .raddr(i_reg),
        .rdata(vi)
    );

    // writes retire straight out of the queue
    assign take   = (state_reg == ST_IDLE) && q_valid;
    assign ram_we = take && !q_job.flag && (q_job.cmd == CMD_WRITE);
    assign win_we = (state_reg == ST_READ) && rd_pend_reg;
    assign q_ready = (state_reg == ST_IDLE);
    assign last_rd = (r_reg == job_reg.r1) && (c_reg == job_reg.c1);
    assign last_j  = (j_reg == WIN_IDX_W'(k_reg - 1'b1));
    // element i is the median when #greater <= k/2 < #greater_or_equal
    assign cand_hit = (gt_reg <= (k_reg >> 1)) && ((k_reg >> 1) < ge_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = (q_job.flag || q_job.cmd == CMD_WRITE)
                                               ? ST_OUT : ST_READ;
            ST_READ: if (rd_pend_reg && ov_reg) state_next = ST_RANK;
            ST_RANK: if (cmp_pend_reg && jdone_reg) state_next = ST_PICK;
            ST_PICK: state_next = cand_hit ? ST_OUT : ST_RANK;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid  = (state_reg == ST_OUT);
        m_value  = res_reg;
        m_count  = cnt_reg;
        m_status = st_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_pend_reg  <= 1'b0;
            cmp_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_pend_reg  <= (state_reg == ST_READ) && !ov_reg;
            cmp_pend_reg <= (state_reg == ST_RANK) && !jdone_reg;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                job_reg   <= q_job;
                r_reg     <= q_job.r0;
                c_reg     <= q_job.c0;
                k_reg     <= '0;
                ov_reg    <= 1'b0;
                i_reg     <= '0;
                j_reg     <= '0;
                jdone_reg <= 1'b0;
                gt_reg    <= '0;
                ge_reg    <= '0;
                res_reg   <= (q_job.flag) ? '0 : q_job.pix;
                cnt_reg   <= '0;
                st_reg    <= q_job.flag;
            end
            ST_READ: begin
                if (rd_pend_reg) begin
                    k_reg <= k_reg + 1'b1;
                end
                if (last_rd) begin
                    ov_reg <= 1'b1;
                end else if (c_reg == job_reg.c1) begin
                    c_reg <= job_reg.c0;
                    r_reg <= r_reg + 1'b1;
                end else begin
                    c_reg <= c_reg + 1'b1;
                end
            end
            ST_RANK: begin
                // window data is registered: it arrives in the cycle after its address
                if (cmp_pend_reg) begin
                    if (vj > vi)  gt_reg <= gt_reg + 1'b1;
                    if (vj >= vi) ge_reg <= ge_reg + 1'b1;
                end
                if (last_j) begin
                    jdone_reg <= 1'b1;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            ST_PICK: begin
                res_reg   <= vi;
                cnt_reg   <= k_reg;
                i_reg     <= i_reg + 1'b1;
                j_reg     <= '0;
                jdone_reg <= 1'b0;
                gt_reg    <= '0;
                ge_reg    <= '0;
            end
            default: ;
        endcase
    end
endmodule

>>> hdl/median_filter_window_unit.sv
// Median filter over a stored 256x256 8-bit frame.
// Input channel s_*: s_command 0 writes s_pixel_in at (s_row, s_col);
// s_command 1 asks for the median of the clipped (2h+1)^2 window there.
// Result channel m_*: one transfer per input transfer, in order.
// A small queue sits between the classifier and the executor, so the
// input side keeps taking items while a result waits on m_ready.
// Write or out-of-frame item: queue slot, then executor IDLE and OUT;
// the executor takes no new item until it is through with the last.
// Compute: store reads of the k window pixels (one per cycle, single
// read port), then per candidate a rank pass over the window and a pick
// step until the median is found; k = neighbors (up to 49).
// Reset (aresetn low, synchronous) empties the queue and restores the
// frame registers to 256x256, h = 1. The pixel store is not cleared.
// A stalled receiver holds the result; queue fills, then s_ready drops.
// Configuration: cfg_we/cfg_index/cfg_data; the user must write them only when idle, the block does not enforce it.
module median_filter_window_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mfw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mfw_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [7:0]                        s_row,
    input  logic [7:0]                        s_col,
    input  logic [7:0]                        s_pixel_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_result_value,
    output logic [5:0]                        m_neighbor_count,
    output logic                              m_status
);
    import mfw_pkg::*;

    logic q_valid, q_ready;
    job_t q_job;

    mfw_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(s_valid), .in_ready(s_ready), .in_cmd(s_command),
        .in_row(s_row), .in_col(s_col), .in_pix(s_pixel_in),
        .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
    );

    mfw_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_value(m_result_value), .m_count(m_neighbor_count),
        .m_status(m_status)
    );

`ifndef SYNTHESIS
    // flagged results carry zero value and count
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_result_value == '0 && m_neighbor_count == '0)
        else $error("flagged result not zero");
    // a compute result never exceeds a full window
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_neighbor_count <= CNT_W'(WIN_MAX))
        else $error("count too large");
    // queue not taken while a result is pending
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !q_ready)
        else $error("queue popped during stall");
`endif
endmodule
